FILE: rtl/nls_pkg.sv
// ----------------------------------------------------------------------------
// nls_pkg
// Types and constants shared by the numeric literal scanner.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package nls_pkg;

    typedef enum logic [2:0] {
        MODE_IDLE,
        MODE_DEC,
        MODE_DECZ,
        MODE_HEX,
        MODE_BIN,
        MODE_STAT
    } scan_mode_t;

    typedef enum logic [1:0] {
        CLASS_OTHER,
        CLASS_SEP,
        CLASS_POINT
    } char_class_t;

    typedef struct packed {
        scan_mode_t  mode;
        logic [63:0] acc;
        logic [4:0]  frac_cnt;
        logic        ovf;
        logic        bad;
        logic        long_sfx;
        logic        point;
        char_class_t last_class;
        logic        digit;
    } scan_state_t;

    typedef struct packed {
        logic [7:0] ch;
        logic       first;
        logic       last;
    } char_word_t;

    typedef struct packed {
        logic [1:0]  token_kind;
        logic [3:0]  error_code;
        logic [63:0] value;
        logic [4:0]  frac_digits;
    } token_word_t;

    localparam scan_state_t STATE_CLEAR = '{
        mode:       MODE_IDLE,
        acc:        64'd0,
        frac_cnt:   5'd0,
        ovf:        1'b0,
        bad:        1'b0,
        long_sfx:   1'b0,
        point:      1'b0,
        last_class: CLASS_OTHER,
        digit:      1'b0
    };

    // character codes
    localparam logic [7:0] CH_ZERO       = 8'h30;
    localparam logic [7:0] CH_ONE        = 8'h31;
    localparam logic [7:0] CH_NINE       = 8'h39;
    localparam logic [7:0] CH_UNDERSCORE = 8'h5F;
    localparam logic [7:0] CH_POINT      = 8'h2E;
    localparam logic [7:0] CH_HASH       = 8'h23;
    localparam logic [7:0] CH_LOWER_L    = 8'h6C;
    localparam logic [7:0] CH_UPPER_L    = 8'h4C;
    localparam logic [7:0] CH_LOWER_X    = 8'h78;
    localparam logic [7:0] CH_UPPER_X    = 8'h58;
    localparam logic [7:0] CH_LOWER_B    = 8'h62;
    localparam logic [7:0] CH_UPPER_B    = 8'h42;
    localparam logic [7:0] CH_LOWER_A    = 8'h61;
    localparam logic [7:0] CH_LOWER_F    = 8'h66;
    localparam logic [7:0] CH_UPPER_A    = 8'h41;
    localparam logic [7:0] CH_UPPER_F    = 8'h46;

    localparam logic [4:0] FRAC_MAX = 5'd19;

    // token kinds
    localparam logic [1:0] KIND_INT    = 2'd0;
    localparam logic [1:0] KIND_LONG   = 2'd1;
    localparam logic [1:0] KIND_FRAC   = 2'd2;
    localparam logic [1:0] KIND_STATIC = 2'd3;

    // error codes
    localparam logic [3:0] ERR_NONE        = 4'd0;
    localparam logic [3:0] ERR_BAD_DEC     = 4'd1;
    localparam logic [3:0] ERR_BAD_HEX     = 4'd2;
    localparam logic [3:0] ERR_BAD_BIN     = 4'd3;
    localparam logic [3:0] ERR_END_SEP     = 4'd4;
    localparam logic [3:0] ERR_END_POINT   = 4'd5;
    localparam logic [3:0] ERR_FRAC        = 4'd6;
    localparam logic [3:0] ERR_LONG_BIG    = 4'd7;
    localparam logic [3:0] ERR_INT_BIG     = 4'd8;
    localparam logic [3:0] ERR_STAT_BAD    = 4'd9;
    localparam logic [3:0] ERR_STAT_EMPTY  = 4'd10;
    localparam logic [3:0] ERR_STAT_BIG    = 4'd11;

endpackage

FILE: rtl/nls_step.sv
// ----------------------------------------------------------------------------
// nls_step
// Per-character scan step: next scan state and the token for a closing word.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module nls_step
    import nls_pkg::*;
(
    input  scan_state_t cur,
    input  char_word_t  word,
    output scan_state_t nxt,
    output token_word_t result,
    output logic        emit
);

    logic [7:0]  c;
    logic        is_digit;
    logic        is_long;
    logic        is_sep;
    logic        is_hex_lo;
    logic        is_hex_up;
    logic [3:0]  dec_val;
    logic [3:0]  hex_val;
    logic [67:0] mul10;
    scan_mode_t  mode_eff;
    logic        skip;

    assign c         = word.ch;
    assign is_digit  = (c >= CH_ZERO) && (c <= CH_NINE);
    assign is_long   = (c == CH_LOWER_L) || (c == CH_UPPER_L);
    assign is_sep    = (c == CH_UNDERSCORE);
    assign is_hex_lo = (c >= CH_LOWER_A) && (c <= CH_LOWER_F);
    assign is_hex_up = (c >= CH_UPPER_A) && (c <= CH_UPPER_F);
    assign dec_val   = 4'(c - CH_ZERO);

    always_comb
    begin
        if (is_digit)
            hex_val = dec_val;
        else if (is_hex_lo)
            hex_val = 4'(c - CH_LOWER_A + 8'd10);
        else if (is_hex_up)
            hex_val = 4'(c - CH_UPPER_A + 8'd10);
        else
            hex_val = 4'd0;
    end

    // times ten as shift-add; a carry past bit 63 means overflow
    assign mul10 = ({4'd0, cur.acc} << 3) + ({4'd0, cur.acc} << 1) + {64'd0, dec_val};

    // next state
    always_comb
    begin
        nxt      = cur;
        mode_eff = cur.mode;
        skip     = 1'b0;
        if (word.first)
        begin
            nxt = STATE_CLEAR;
            if (is_digit)
            begin
                nxt.acc  = {60'd0, dec_val};
                nxt.mode = (c == CH_ZERO) ? MODE_DECZ : MODE_DEC;
            end
            else if (c == CH_POINT)
            begin
                nxt.point      = 1'b1;
                nxt.last_class = CLASS_POINT;
                nxt.mode       = MODE_DEC;
            end
            else if (c == CH_HASH)
                nxt.mode = MODE_STAT;
            else
            begin
                nxt.bad  = 1'b1;
                nxt.mode = MODE_DEC;
            end
        end
        else if (cur.mode != MODE_IDLE && !cur.long_sfx)
        begin
            if (cur.mode == MODE_DECZ)
            begin
                if (c == CH_LOWER_X || c == CH_UPPER_X)
                begin
                    mode_eff = MODE_HEX;
                    skip     = 1'b1;
                end
                else if (c == CH_LOWER_B || c == CH_UPPER_B)
                begin
                    mode_eff = MODE_BIN;
                    skip     = 1'b1;
                end
                else
                    mode_eff = MODE_DEC;
            end
            nxt.mode = mode_eff;
            if (skip)
                nxt.last_class = CLASS_OTHER;
            else
            begin
                case (mode_eff)
                    MODE_DEC:
                    begin
                        nxt.last_class = is_sep ? CLASS_SEP :
                                         (c == CH_POINT) ? CLASS_POINT : CLASS_OTHER;
                        if (is_digit)
                        begin
                            if (!cur.ovf)
                            begin
                                if (mul10[67:64] != 4'd0)
                                    nxt.ovf = 1'b1;
                                else if (cur.point && cur.frac_cnt >= FRAC_MAX)
                                    nxt.ovf = 1'b1;
                                else
                                begin
                                    nxt.acc = mul10[63:0];
                                    if (cur.point)
                                        nxt.frac_cnt = cur.frac_cnt + 5'd1;
                                end
                            end
                        end
                        else if (is_sep)
                            nxt.bad = cur.bad;
                        else if (!cur.point && c == CH_POINT)
                            nxt.point = 1'b1;
                        else if (!cur.point && is_long)
                            nxt.long_sfx = 1'b1;
                        else
                            nxt.bad = 1'b1;
                    end
                    MODE_HEX:
                    begin
                        nxt.last_class = is_sep ? CLASS_SEP : CLASS_OTHER;
                        if (is_long && !is_digit && !is_hex_lo && !is_hex_up)
                            nxt.long_sfx = 1'b1;
                        else if (!is_sep)
                        begin
                            // a bad character still shifts in a zero nibble
                            if (!is_digit && !is_hex_lo && !is_hex_up)
                                nxt.bad = 1'b1;
                            if (cur.acc[63:60] != 4'd0)
                                nxt.ovf = 1'b1;
                            else
                                nxt.acc = {cur.acc[59:0], hex_val};
                        end
                    end
                    MODE_BIN:
                    begin
                        nxt.last_class = is_sep ? CLASS_SEP : CLASS_OTHER;
                        if (c == CH_ZERO || c == CH_ONE)
                        begin
                            if (cur.acc[63])
                                nxt.ovf = 1'b1;
                            nxt.acc = {cur.acc[62:0], c[0]};
                        end
                        else if (is_long)
                            nxt.long_sfx = 1'b1;
                        else if (!is_sep)
                            nxt.bad = 1'b1;
                    end
                    MODE_STAT:
                    begin
                        nxt.last_class = is_sep ? CLASS_SEP :
                                         (c == CH_POINT) ? CLASS_POINT : CLASS_OTHER;
                        if (is_digit)
                        begin
                            nxt.digit = 1'b1;
                            if (!cur.ovf)
                            begin
                                nxt.acc = mul10[63:0];
                                if (mul10[63:31] != 33'd0)
                                    nxt.ovf = 1'b1;
                            end
                        end
                        else
                            nxt.bad = 1'b1;
                    end
                    default:
                    begin
                        nxt = cur;
                    end
                endcase
            end
        end
    end

    // token for a closing word, taken from the updated state
    always_comb
    begin
        emit   = word.last && (word.first || cur.mode != MODE_IDLE);
        result = '{token_kind: KIND_INT, error_code: ERR_NONE,
                   value: 64'd0, frac_digits: 5'd0};
        case (nxt.mode)
            MODE_STAT:
            begin
                if (nxt.bad)
                    result.error_code = ERR_STAT_BAD;
                else if (!nxt.digit)
                    result.error_code = ERR_STAT_EMPTY;
                else if (nxt.ovf)
                    result.error_code = ERR_STAT_BIG;
                else
                begin
                    result.token_kind = KIND_STATIC;
                    result.value      = nxt.acc;
                end
            end
            MODE_DEC, MODE_DECZ:
            begin
                if (nxt.bad)
                    result.error_code = ERR_BAD_DEC;
                else if (nxt.last_class == CLASS_SEP)
                    result.error_code = ERR_END_SEP;
                else if (nxt.last_class == CLASS_POINT)
                    result.error_code = ERR_END_POINT;
                else if (nxt.point)
                begin
                    if (nxt.ovf)
                        result.error_code = ERR_FRAC;
                    else
                    begin
                        result.token_kind  = KIND_FRAC;
                        result.value       = nxt.acc;
                        result.frac_digits = nxt.frac_cnt;
                    end
                end
                else if (nxt.long_sfx)
                begin
                    if (nxt.ovf || nxt.acc[63])
                        result.error_code = ERR_LONG_BIG;
                    else
                    begin
                        result.token_kind = KIND_LONG;
                        result.value      = nxt.acc;
                    end
                end
                else if (nxt.ovf || nxt.acc[63:31] != 33'd0)
                    result.error_code = ERR_INT_BIG;
                else
                    result.value = nxt.acc;
            end
            default:
            begin
                // hex and binary
                if (nxt.bad)
                    result.error_code = (nxt.mode == MODE_HEX) ? ERR_BAD_HEX : ERR_BAD_BIN;
                else if (nxt.last_class == CLASS_SEP)
                    result.error_code = ERR_END_SEP;
                else if (nxt.long_sfx)
                begin
                    if (nxt.ovf)
                        result.error_code = ERR_LONG_BIG;
                    else
                    begin
                        result.token_kind = KIND_LONG;
                        result.value      = nxt.acc;
                    end
                end
                else if (nxt.ovf || nxt.acc[63:32] != 32'd0)
                    result.error_code = ERR_INT_BIG;
                else
                    result.value = {32'd0, nxt.acc[31:0]};
            end
        endcase
    end

endmodule

FILE: rtl/numeric_literal_scanner.sv
// ----------------------------------------------------------------------------
// numeric_literal_scanner
// Scans framed numeric literals one character a word and emits one token
// word at each literal's closing character.
// ----------------------------------------------------------------------------
//  channel   dir  handshake                  payload
//  char      in   char_valid / char_ready    char_data  (ch, first, last)
//  token     out  token_valid / token_ready  token_data (kind, error, value, frac)
//
//  one character word is taken every cycle while char_ready is high; the scan
//  state register loop closes through one times-ten shift-add and its carry check
//  a token appears in the output register the cycle after its closing word
//  reset clears the scan state and empties the output register
//  char_ready drops only while a token is held and token_ready is low
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module numeric_literal_scanner
    import nls_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        char_valid,
    output logic        char_ready,
    input  char_word_t  char_data,
    output logic        token_valid,
    input  logic        token_ready,
    output token_word_t token_data
);

    scan_state_t state_reg;
    scan_state_t state_next;
    scan_state_t step_state;
    token_word_t step_token;
    logic        step_emit;
    logic        accept;

    logic        token_valid_reg;
    logic        token_valid_next;
    token_word_t token_data_reg;

    nls_step u_step (
        .cur    (state_reg),
        .word   (char_data),
        .nxt    (step_state),
        .result (step_token),
        .emit   (step_emit)
    );

    assign char_ready = !token_valid_reg || token_ready;
    assign accept     = char_valid && char_ready;

    // a closing word always leaves the scanner empty
    always_comb
    begin
        state_next = state_reg;
        if (accept)
            state_next = char_data.last ? STATE_CLEAR : step_state;
    end

    always_comb
    begin
        token_valid_next = token_valid_reg && !token_ready;
        if (accept && step_emit)
            token_valid_next = 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= STATE_CLEAR;
            token_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg       <= state_next;
            token_valid_reg <= token_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept && step_emit)
            token_data_reg <= step_token;
    end

    assign token_valid = token_valid_reg;
    assign token_data  = token_data_reg;

    a_close_clears: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && char_data.last) |=> (state_reg.mode == MODE_IDLE))
        else $error("scan state not cleared after closing word");

    a_close_emits: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && char_data.last && (char_data.first || state_reg.mode != MODE_IDLE))
        |=> token_valid)
        else $error("closing word produced no token");

    a_stray_ignored: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && !char_data.first && state_reg.mode == MODE_IDLE) |=>
        (state_reg.mode == MODE_IDLE && state_reg.acc == 64'd0))
        else $error("stray word opened a literal");

    a_frac_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg.frac_cnt <= FRAC_MAX) &&
        (state_reg.point || state_reg.frac_cnt == 5'd0))
        else $error("fraction digit count out of range");

    a_error_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (token_valid && token_data.error_code != ERR_NONE) |->
        (token_data.value == 64'd0 && token_data.token_kind == KIND_INT))
        else $error("error token carries a value");

endmodule

FILE: dv/tb.sv
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for numeric_literal_scanner. Character words are
// streamed in from a queue and predicted by a lexer model held in the bench.
// Each token word taken from the block is checked against the oldest
// prediction. Three idling phases are run, with one long receiver hold-off.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb;
    import nls_pkg::*;

    localparam int CLK_PERIOD     = 10;
    localparam int HOLDOFF_CYCLES = 300;
    localparam int DRAIN_CYCLES   = 20;
    localparam int TIMEOUT_CYCLES = 200_000;
    localparam int PHASE_CHARS    = 550;
    localparam int MAX_REPORTS    = 10;

    localparam logic [63:0] U64_MAX  = '1;
    localparam logic [63:0] INT_MAX  = 64'h0000_0000_7FFF_FFFF;
    localparam logic [63:0] UINT_MAX = 64'h0000_0000_FFFF_FFFF;
    localparam logic [63:0] LONG_MAX = 64'h7FFF_FFFF_FFFF_FFFF;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        char_valid = 1'b0;
    logic        char_ready;
    char_word_t  char_data = '0;
    logic        token_valid;
    logic        token_ready = 1'b0;
    token_word_t token_data;

    char_word_t  pending_chars[$];
    token_word_t expected_tokens[$];
    logic [7:0]  lit_chars[$];
    int          chars_queued = 0;
    int          chars_taken = 0;
    int          mismatch_count = 0;
    int unsigned send_idle_pct = 0;
    int unsigned recv_idle_pct = 0;
    bit          holdoff_start = 1'b0;
    logic        rx_hold = 1'b0;

    // lexer state of the prediction
    scan_state_t lx;

    numeric_literal_scanner u_top (
        .clk         (clk),
        .rst_n       (rst_n),
        .char_valid  (char_valid),
        .char_ready  (char_ready),
        .char_data   (char_data),
        .token_valid (token_valid),
        .token_ready (token_ready),
        .token_data  (token_data)
    );

    always #(CLK_PERIOD / 2) clk = ~clk;

    function automatic bit is_dec(logic [7:0] c);
        return c >= CH_ZERO && c <= CH_NINE;
    endfunction

    function automatic bit is_long_mark(logic [7:0] c);
        return c == CH_LOWER_L || c == CH_UPPER_L;
    endfunction

    function automatic void lex_dec(logic [7:0] c);
        logic [63:0] d;
        if (c == CH_UNDERSCORE)
            lx.last_class = CLASS_SEP;
        else if (c == CH_POINT)
            lx.last_class = CLASS_POINT;
        else
            lx.last_class = CLASS_OTHER;
        if (is_dec(c))
        begin
            d = {56'd0, c - CH_ZERO};
            // accumulator freezes once overflow is seen
            if (!lx.ovf)
            begin
                if (lx.acc > (U64_MAX - d) / 64'd10)
                    lx.ovf = 1'b1;
                else if (lx.point && lx.frac_cnt >= FRAC_MAX)
                    lx.ovf = 1'b1;
                else
                begin
                    lx.acc = lx.acc * 64'd10 + d;
                    if (lx.point)
                        lx.frac_cnt = lx.frac_cnt + 5'd1;
                end
            end
        end
        else if (c == CH_UNDERSCORE)
        begin
        end
        else if (!lx.point && c == CH_POINT)
            lx.point = 1'b1;
        else if (!lx.point && is_long_mark(c))
            lx.long_sfx = 1'b1;
        else
            lx.bad = 1'b1;
    endfunction

    function automatic void lex_hex(logic [7:0] c);
        logic [63:0] add;
        bit          shift_in;
        add = '0;
        shift_in = 1'b1;
        lx.last_class = (c == CH_UNDERSCORE) ? CLASS_SEP : CLASS_OTHER;
        if (is_dec(c))
            add = {56'd0, c - CH_ZERO};
        else if (c >= CH_LOWER_A && c <= CH_LOWER_F)
            add = {56'd0, c - CH_LOWER_A + 8'd10};
        else if (c >= CH_UPPER_A && c <= CH_UPPER_F)
            add = {56'd0, c - CH_UPPER_A + 8'd10};
        else if (c == CH_UNDERSCORE)
            shift_in = 1'b0;
        else if (is_long_mark(c))
        begin
            lx.long_sfx = 1'b1;
            shift_in = 1'b0;
        end
        else
            lx.bad = 1'b1;
        // a bad character still shifts in a zero nibble
        if (shift_in)
        begin
            if (lx.acc > ((U64_MAX - add) >> 4))
                lx.ovf = 1'b1;
            else
                lx.acc = (lx.acc << 4) + add;
        end
    endfunction

    function automatic void lex_bin(logic [7:0] c);
        logic [63:0] d;
        lx.last_class = (c == CH_UNDERSCORE) ? CLASS_SEP : CLASS_OTHER;
        if (c == CH_ZERO || c == CH_ONE)
        begin
            d = {63'd0, c == CH_ONE};
            if (lx.acc > ((U64_MAX - d) >> 1))
                lx.ovf = 1'b1;
            lx.acc = (lx.acc << 1) + d;
        end
        else if (c == CH_UNDERSCORE)
        begin
        end
        else if (is_long_mark(c))
            lx.long_sfx = 1'b1;
        else
            lx.bad = 1'b1;
    endfunction

    function automatic void lex_stat(logic [7:0] c);
        if (c == CH_UNDERSCORE)
            lx.last_class = CLASS_SEP;
        else if (c == CH_POINT)
            lx.last_class = CLASS_POINT;
        else
            lx.last_class = CLASS_OTHER;
        if (is_dec(c))
        begin
            lx.digit = 1'b1;
            if (!lx.ovf)
            begin
                lx.acc = lx.acc * 64'd10 + {56'd0, c - CH_ZERO};
                if (lx.acc > INT_MAX)
                    lx.ovf = 1'b1;
            end
        end
        else
            lx.bad = 1'b1;
    endfunction

    function automatic token_word_t lex_close();
        token_word_t t;
        t = '0;
        if (lx.mode == MODE_STAT)
        begin
            if (lx.bad)
                t.error_code = ERR_STAT_BAD;
            else if (!lx.digit)
                t.error_code = ERR_STAT_EMPTY;
            else if (lx.ovf)
                t.error_code = ERR_STAT_BIG;
            else
            begin
                t.token_kind = KIND_STATIC;
                t.value = lx.acc;
            end
        end
        else if (lx.mode == MODE_DEC || lx.mode == MODE_DECZ)
        begin
            if (lx.bad)
                t.error_code = ERR_BAD_DEC;
            else if (lx.last_class == CLASS_SEP)
                t.error_code = ERR_END_SEP;
            else if (lx.last_class == CLASS_POINT)
                t.error_code = ERR_END_POINT;
            else if (lx.point)
            begin
                if (lx.ovf)
                    t.error_code = ERR_FRAC;
                else
                begin
                    t.token_kind = KIND_FRAC;
                    t.value = lx.acc;
                    t.frac_digits = lx.frac_cnt;
                end
            end
            else if (lx.long_sfx)
            begin
                if (lx.ovf || lx.acc > LONG_MAX)
                    t.error_code = ERR_LONG_BIG;
                else
                begin
                    t.token_kind = KIND_LONG;
                    t.value = lx.acc;
                end
            end
            else if (lx.ovf || lx.acc > INT_MAX)
                t.error_code = ERR_INT_BIG;
            else
                t.value = lx.acc;
        end
        else
        begin
            // hex and binary
            if (lx.bad)
                t.error_code = (lx.mode == MODE_HEX) ? ERR_BAD_HEX : ERR_BAD_BIN;
            else if (lx.last_class == CLASS_SEP)
                t.error_code = ERR_END_SEP;
            else if (lx.long_sfx)
            begin
                if (lx.ovf)
                    t.error_code = ERR_LONG_BIG;
                else
                begin
                    t.token_kind = KIND_LONG;
                    t.value = lx.acc;
                end
            end
            else if (lx.ovf || lx.acc > UINT_MAX)
                t.error_code = ERR_INT_BIG;
            else
                t.value = {32'd0, lx.acc[31:0]};
        end
        return t;
    endfunction

    task automatic lex_step(input char_word_t w, output bit emit, output token_word_t tok);
        logic [7:0] c;
        bit         prefix;
        c = w.ch;
        emit = 1'b0;
        tok = '0;
        prefix = 1'b0;
        if (w.first)
        begin
            lx = STATE_CLEAR;
            if (is_dec(c))
            begin
                lx.acc = {56'd0, c - CH_ZERO};
                lx.mode = (c == CH_ZERO) ? MODE_DECZ : MODE_DEC;
            end
            else if (c == CH_POINT)
            begin
                lx.point = 1'b1;
                lx.last_class = CLASS_POINT;
                lx.mode = MODE_DEC;
            end
            else if (c == CH_HASH)
                lx.mode = MODE_STAT;
            else
            begin
                lx.bad = 1'b1;
                lx.mode = MODE_DEC;
            end
        end
        else if (lx.mode == MODE_IDLE)
            return;
        else if (!lx.long_sfx)
        begin
            if (lx.mode == MODE_DECZ)
            begin
                prefix = 1'b1;
                if (c == CH_LOWER_X || c == CH_UPPER_X)
                    lx.mode = MODE_HEX;
                else if (c == CH_LOWER_B || c == CH_UPPER_B)
                    lx.mode = MODE_BIN;
                else
                begin
                    lx.mode = MODE_DEC;
                    prefix = 1'b0;
                end
                if (prefix)
                    lx.last_class = CLASS_OTHER;
            end
            if (!prefix)
            begin
                case (lx.mode)
                    MODE_DEC: lex_dec(c);
                    MODE_HEX: lex_hex(c);
                    MODE_BIN: lex_bin(c);
                    default:  lex_stat(c);
                endcase
            end
        end
        if (w.last)
        begin
            tok = lex_close();
            emit = 1'b1;
            lx = STATE_CLEAR;
        end
    endtask

    function automatic void queue_word(logic [7:0] c, bit first, bit last);
        char_word_t w;
        w.ch = c;
        w.first = first;
        w.last = last;
        pending_chars.insert(pending_chars.size(), w);
        chars_queued++;
    endfunction

    function automatic void add_char(logic [7:0] c);
        lit_chars.insert(lit_chars.size(), c);
    endfunction

    function automatic void queue_text(string s, bit close);
        for (int i = 0; i < s.len(); i++)
            queue_word(s[i], i == 0, close && i == s.len() - 1);
    endfunction

    function automatic void add_digits(int unsigned count, int unsigned radix, bit seps);
        int unsigned pick;
        for (int unsigned i = 0; i < count; i++)
        begin
            if (seps && i != 0 && $urandom_range(9) == 0)
                add_char(CH_UNDERSCORE);
            pick = $urandom_range((radix == 16) ? 21 : radix - 1);
            if (pick < 10)
                add_char(8'(CH_ZERO + pick));
            else if (pick < 16)
                add_char(8'(CH_LOWER_A + pick - 10));
            else
                add_char(8'(CH_UPPER_A + pick - 16));
        end
    endfunction

    // optional long suffix, sometimes with trailing junk that gets dropped
    function automatic void add_suffix();
        if ($urandom_range(3) != 0)
            return;
        add_char($urandom_range(1) ? CH_LOWER_L : CH_UPPER_L);
        if ($urandom_range(3) == 0)
            repeat ($urandom_range(2, 1)) add_char(8'($urandom_range(255)));
    endfunction

    function automatic void build_literal(int unsigned sel);
        int unsigned n;
        case (sel)
            0:
            begin
                n = ($urandom_range(6) == 0) ? $urandom_range(22, 17) : $urandom_range(10, 1);
                add_digits(n, 10, 1'b1);
                add_suffix();
            end
            1:
            begin
                n = ($urandom_range(6) == 0) ? $urandom_range(20, 10) : $urandom_range(4, 0);
                add_digits(n, 10, 1'b1);
                add_char(CH_POINT);
                n = ($urandom_range(5) == 0) ? $urandom_range(22, 17) : $urandom_range(8, 1);
                add_digits(n, 10, 1'b1);
            end
            2:
            begin
                add_char(CH_ZERO);
                add_char($urandom_range(1) ? CH_LOWER_X : CH_UPPER_X);
                n = ($urandom_range(6) == 0) ? $urandom_range(18, 14) : $urandom_range(8, 0);
                add_digits(n, 16, 1'b1);
                add_suffix();
            end
            3:
            begin
                add_char(CH_ZERO);
                add_char($urandom_range(1) ? CH_LOWER_B : CH_UPPER_B);
                n = ($urandom_range(7) == 0) ? $urandom_range(66, 30) : $urandom_range(12, 0);
                add_digits(n, 2, 1'b1);
                add_suffix();
            end
            default:
            begin
                add_char(CH_HASH);
                n = ($urandom_range(5) == 0) ? $urandom_range(12, 9) : $urandom_range(8, 0);
                add_digits(n, 10, 1'b0);
            end
        endcase
    endfunction

    // mostly well-formed literals, some broken ones and some raw noise
    function automatic void queue_literal();
        int unsigned sel;
        bit          close;
        sel = $urandom_range(99);
        if (sel >= 90)
        begin
            repeat ($urandom_range(4, 1))
                queue_word(8'($urandom_range(255)), 1'($urandom_range(1)),
                           1'($urandom_range(1)));
            return;
        end
        lit_chars.delete();
        build_literal($urandom_range(4));
        close = 1'b1;
        if (sel >= 75)
        begin
            case ($urandom_range(3))
                0:
                begin
                    if (lit_chars.size() > 1)
                        lit_chars[$urandom_range(lit_chars.size() - 1, 1)] =
                            8'($urandom_range(255));
                    else
                        add_char(8'($urandom_range(255)));
                end
                1: add_char(CH_UNDERSCORE);
                2: add_char(CH_POINT);
                default: close = 1'b0;
            endcase
        end
        for (int i = 0; i < lit_chars.size(); i++)
            queue_word(lit_chars[i], i == 0, close && i == lit_chars.size() - 1);
    endfunction

    function automatic void log_mismatch(string what, token_word_t want, token_word_t got);
        mismatch_count++;
        if (mismatch_count <= MAX_REPORTS)
        begin
            $display("%0t token %s: expected kind %0d err %0d value %h frac %0d",
                     $realtime, what, want.token_kind, want.error_code, want.value,
                     want.frac_digits);
            $display("    got kind %0d err %0d value %h frac %0d",
                     got.token_kind, got.error_code, got.value, got.frac_digits);
        end
    endfunction

    task automatic wait_drained();
        while (chars_taken != chars_queued || expected_tokens.size() != 0)
            @(posedge clk);
    endtask

    always @(posedge clk or negedge rst_n)
    begin : char_driver
        bit          emit;
        token_word_t tok;
        if (!rst_n)
        begin
            char_valid <= 1'b0;
            char_data <= '0;
        end
        else
        begin
            if (char_valid && char_ready)
            begin
                lex_step(char_data, emit, tok);
                if (emit)
                    expected_tokens.insert(expected_tokens.size(), tok);
                chars_taken++;
            end
            if (!char_valid || char_ready)
            begin
                if (pending_chars.size() != 0 && $urandom_range(99) >= send_idle_pct)
                begin
                    char_valid <= 1'b1;
                    char_data <= pending_chars[0];
                    pending_chars.delete(0);
                end
                else
                    char_valid <= 1'b0;
            end
        end
    end

    always @(posedge clk or negedge rst_n)
    begin : token_monitor
        token_word_t want;
        if (!rst_n)
            token_ready <= 1'b0;
        else
        begin
            if (token_valid && token_ready)
            begin
                if (expected_tokens.size() == 0)
                    log_mismatch("unexpected", '0, token_data);
                else
                begin
                    want = expected_tokens[0];
                    expected_tokens.delete(0);
                    if (token_data.token_kind !== want.token_kind ||
                        token_data.error_code !== want.error_code ||
                        token_data.value !== want.value ||
                        token_data.frac_digits !== want.frac_digits)
                        log_mismatch("mismatch", want, token_data);
                end
            end
            token_ready <= !rx_hold && ($urandom_range(99) >= recv_idle_pct);
        end
    end

    // long receiver stall so the output fills and the input backs up
    initial
    begin : receiver_holdoff
        wait (holdoff_start);
        @(posedge clk);
        rx_hold <= 1'b1;
        repeat (HOLDOFF_CYCLES) @(posedge clk);
        rx_hold <= 1'b0;
    end

    initial
    begin : watchdog
        #(TIMEOUT_CYCLES * CLK_PERIOD);
        $display("Simulation FAILED");
        $finish;
    end

    initial
    begin : stimulus
        lx = STATE_CLEAR;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        send_idle_pct = 7;
        recv_idle_pct = 56;
        queue_text("7", 1'b1);
        queue_text("0x", 1'b1);
        queue_text("1.5", 1'b1);
        queue_text("3L", 1'b1);
        queue_text("9Lq", 1'b1);
        queue_text("#9", 1'b1);
        queue_text("#", 1'b1);
        queue_text("1_", 1'b1);
        queue_text("0xg", 1'b1);
        queue_word(8'hFF, 1'b1, 1'b1);
        // nothing open here, so this word is dropped
        queue_word(8'h00, 1'b0, 1'b1);
        queue_text("4", 1'b0);
        queue_text("8", 1'b1);
        while (chars_queued < PHASE_CHARS)
            queue_literal();
        wait_drained();

        send_idle_pct = 56;
        recv_idle_pct = 7;
        while (chars_queued < 2 * PHASE_CHARS)
            queue_literal();
        wait_drained();

        send_idle_pct = 0;
        recv_idle_pct = 0;
        holdoff_start = 1'b1;
        while (chars_queued < 3 * PHASE_CHARS)
            queue_literal();
        wait_drained();

        repeat (DRAIN_CYCLES) @(posedge clk);
        if (mismatch_count == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule

FILE: files.f
rtl/nls_pkg.sv
rtl/nls_step.sv
rtl/numeric_literal_scanner.sv
dv/tb.sv
